// ===== rtl/pcdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdc_pkg
// Shared constants for the pointer click/drag classifier: codes, register
// indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package pcdc_pkg;

   localparam int NUM_BUTTONS_DEF = 4;
   localparam int COORD_BITS_DEF  = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_WINDOW_WIDTH  = 3'd0;
   localparam csr_index_type CSR_WINDOW_HEIGHT = 3'd1;
   localparam csr_index_type CSR_DRAG_MODE     = 3'd2;
   localparam csr_index_type CSR_THRESH_B0     = 3'd3;
   localparam csr_index_type CSR_THRESH_B1     = 3'd4;
   localparam csr_index_type CSR_THRESH_B2     = 3'd5;
   localparam csr_index_type CSR_THRESH_B3     = 3'd6;

   localparam int WINDOW_BITS = 15;
   localparam int MODE_BITS   = 8;
   localparam int THRESH_BITS = 16;
   localparam int NUM_THRESH  = 4;

   localparam logic [WINDOW_BITS-1:0] WINDOW_WIDTH_RST  = 15'd1920;
   localparam logic [WINDOW_BITS-1:0] WINDOW_HEIGHT_RST = 15'd1080;

   // request kinds
   localparam logic [1:0] REQ_MOVE  = 2'd0;
   localparam logic [1:0] REQ_DOWN  = 2'd1;
   localparam logic [1:0] REQ_UP    = 2'd2;
   localparam logic [1:0] REQ_ABORT = 2'd3;

   // result event codes
   localparam logic [2:0] EVT_HOVER      = 3'd0;
   localparam logic [2:0] EVT_CLICK      = 3'd1;
   localparam logic [2:0] EVT_DRAG_BEGIN = 3'd2;
   localparam logic [2:0] EVT_DRAG       = 3'd3;
   localparam logic [2:0] EVT_DRAG_END   = 3'd4;
   localparam logic [2:0] EVT_DRAG_ABORT = 3'd5;

   // per-button drag modes
   localparam logic [1:0] MODE_DISABLED = 2'd0;
   localparam logic [1:0] MODE_HIDE     = 2'd2;

endpackage

// ===== rtl/pcdc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdc channel interfaces
// Valid/ready channels for pointer events in and classified events out.
// ----------------------------------------------------------------------------
interface pcdc_req_if #(
   parameter int COORD_BITS = pcdc_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic [1:0]                   button;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic                         cursor_visible;

   modport source (output valid, req_type, button, pos_x, pos_y, cursor_visible,
                   input ready);
   modport sink   (input valid, req_type, button, pos_x, pos_y, cursor_visible,
                   output ready);
endinterface

interface pcdc_rsp_if #(
   parameter int COORD_BITS = pcdc_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   event_code;
   logic [1:0]                   event_button;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic                         hide_cursor;
   logic                         show_cursor;
   logic                         last;

   modport source (output valid, event_code, event_button, out_x, out_y,
                   hide_cursor, show_cursor, last, input ready);
   modport sink   (input valid, event_code, event_button, out_x, out_y,
                   hide_cursor, show_cursor, last, output ready);
endinterface

// ===== rtl/pointer_click_drag_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_click_drag_classifier
// Sorts pointer move/down/up/abort items into hover, click and drag events.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one pointer item per valid/ready handshake: the kind
//   (move, down, up, abort), the button, the signed position and whether the
//   cursor is visible. rsp_ch returns zero, one or two event items per input;
//   'last' marks the final event of an input. A down never yields an event,
//   an abort always yields one, a move that starts a drag yields two.
//   csr_we/csr_index/csr_wdata write the window size, the drag mode table and
//   the four drag thresholds; write them only while the block is idle.
// Pipeline and throughput:
//   An accepted item sits in the input register, is classified and written
//   into a 4-entry result queue, and its first event then shows on rsp_ch.
//   One item is taken per cycle as long as the queue has two free entries;
//   while rsp_ch.ready is high the queue drains one event per cycle, so only
//   inputs that yield two events can slow the input side.
// Reset and stall:
//   Synchronous reset loads the default window (1920 x 1080), clears modes and
//   thresholds, releases the button and empties the queue. When the receiver
//   stalls, events wait in the queue and req_ch.ready drops once the input
//   register holds an item that the queue cannot take.
// ----------------------------------------------------------------------------
module pointer_click_drag_classifier #(
   parameter int NUM_BUTTONS = pcdc_pkg::NUM_BUTTONS_DEF,
   parameter int COORD_BITS  = pcdc_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   pcdc_req_if.sink                            req_ch,
   pcdc_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  pcdc_pkg::csr_index_type             csr_index,
   input  logic [pcdc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW = COORD_BITS;
   // wide enough for the window size and the coordinate maximum
   localparam int EW = ((CW > pcdc_pkg::WINDOW_BITS) ? CW : pcdc_pkg::WINDOW_BITS) + 1;
   // wide enough for the Manhattan distance and the threshold
   localparam int DW = ((CW + 2) > pcdc_pkg::THRESH_BITS) ? (CW + 2) : pcdc_pkg::THRESH_BITS;
   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam int QDEPTH = 4;
   localparam int QPTR   = 2;

   typedef struct packed {
      logic [2:0]           event_code;
      logic [1:0]           event_button;
      logic [CW-1:0]        out_x;
      logic [CW-1:0]        out_y;
      logic                 hide_cursor;
      logic                 show_cursor;
      logic                 last;
   } result_type;

   // ---------------- configuration registers ----------------
   logic [pcdc_pkg::WINDOW_BITS-1:0] win_w_ff, win_h_ff;
   logic [pcdc_pkg::MODE_BITS-1:0]   mode_tbl_ff;
   logic [pcdc_pkg::THRESH_BITS-1:0] thresh_ff [pcdc_pkg::NUM_THRESH];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_w_ff    <= pcdc_pkg::WINDOW_WIDTH_RST;
         win_h_ff    <= pcdc_pkg::WINDOW_HEIGHT_RST;
         mode_tbl_ff <= '0;
         for (int i = 0; i < pcdc_pkg::NUM_THRESH; i++) begin
            thresh_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            pcdc_pkg::CSR_WINDOW_WIDTH:  win_w_ff    <= csr_wdata[pcdc_pkg::WINDOW_BITS-1:0];
            pcdc_pkg::CSR_WINDOW_HEIGHT: win_h_ff    <= csr_wdata[pcdc_pkg::WINDOW_BITS-1:0];
            pcdc_pkg::CSR_DRAG_MODE:     mode_tbl_ff <= csr_wdata[pcdc_pkg::MODE_BITS-1:0];
            pcdc_pkg::CSR_THRESH_B0:     thresh_ff[0] <= csr_wdata;
            pcdc_pkg::CSR_THRESH_B1:     thresh_ff[1] <= csr_wdata;
            pcdc_pkg::CSR_THRESH_B2:     thresh_ff[2] <= csr_wdata;
            pcdc_pkg::CSR_THRESH_B3:     thresh_ff[3] <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                 s1_valid_ff;
   logic [1:0]           s1_req_ff;
   logic [1:0]           s1_btn_ff;
   logic [CW-1:0]        s1_x_ff, s1_y_ff;
   logic                 s1_vis_ff;
   logic [QPTR:0]        count_ff;
   logic                 s1_go;
   logic                 req_fire;

   // advance only when the queue can take two events
   assign s1_go        = s1_valid_ff && (count_ff <= (QPTR+1)'(QDEPTH - 2));
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_fire) begin
         s1_req_ff <= req_ch.req_type;
         s1_btn_ff <= req_ch.button;
         s1_x_ff   <= req_ch.pos_x;
         s1_y_ff   <= req_ch.pos_y;
         s1_vis_ff <= req_ch.cursor_visible;
      end
   end

   // ---------------- gesture state ----------------
   logic          held_valid_ff, held_valid_in;
   logic [1:0]    held_button_ff, held_button_in;
   logic          drag_active_ff, drag_active_in;
   logic          click_pending_ff, click_pending_in;
   logic [CW-1:0] press_x_ff, press_x_in;
   logic [CW-1:0] press_y_ff, press_y_in;

   // ---------------- classification ----------------
   logic [CW-1:0]   hi_x, hi_y, cx, cy;
   logic [CW:0]     dx, dy, adx, ady;
   logic [CW+1:0]   manhattan;
   logic            exceed;
   logic [1:0]      held_mode;
   logic [1:0]      move_btn;
   logic            begin_drag;
   logic [1:0]      n_push;
   result_type      res0, res1;

   always_comb begin
      // upper clamp saturates at the largest positive coordinate
      hi_x = (EW'(win_w_ff) > EW'(COORD_MAX)) ? COORD_MAX : CW'(win_w_ff);
      hi_y = (EW'(win_h_ff) > EW'(COORD_MAX)) ? COORD_MAX : CW'(win_h_ff);
      cx   = s1_x_ff[CW-1] ? '0 : ((s1_x_ff > hi_x) ? hi_x : s1_x_ff);
      cy   = s1_y_ff[CW-1] ? '0 : ((s1_y_ff > hi_y) ? hi_y : s1_y_ff);

      // Manhattan distance from the unclamped press position
      dx        = {cx[CW-1], cx} - {press_x_ff[CW-1], press_x_ff};
      dy        = {cy[CW-1], cy} - {press_y_ff[CW-1], press_y_ff};
      adx       = dx[CW] ? (~dx + 1'b1) : dx;
      ady       = dy[CW] ? (~dy + 1'b1) : dy;
      manhattan = (CW+2)'(adx) + (CW+2)'(ady);
      exceed    = DW'(manhattan) > DW'(thresh_ff[held_button_ff]);

      held_mode = mode_tbl_ff[{held_button_ff, 1'b0} +: 2];
      move_btn  = held_valid_ff ? held_button_ff : s1_btn_ff;

      held_valid_in    = held_valid_ff;
      held_button_in   = held_button_ff;
      drag_active_in   = drag_active_ff;
      click_pending_in = click_pending_ff;
      press_x_in       = press_x_ff;
      press_y_in       = press_y_ff;
      begin_drag       = 1'b0;
      n_push           = 2'd0;
      res0             = '0;
      res1             = '0;

      case (s1_req_ff)
         pcdc_pkg::REQ_MOVE: begin
            if (held_valid_ff && !drag_active_ff && click_pending_ff && exceed) begin
               click_pending_in = 1'b0;
               if (held_mode != pcdc_pkg::MODE_DISABLED) begin
                  drag_active_in = 1'b1;
                  begin_drag     = 1'b1;
               end
            end
            res0 = '{event_code: pcdc_pkg::EVT_DRAG_BEGIN, event_button: move_btn,
                     out_x: cx, out_y: cy, hide_cursor: (held_mode == pcdc_pkg::MODE_HIDE),
                     show_cursor: 1'b0, last: 1'b0};
            res1 = '{event_code: pcdc_pkg::EVT_DRAG, event_button: move_btn,
                     out_x: cx, out_y: cy, hide_cursor: 1'b0, show_cursor: 1'b0,
                     last: 1'b1};
            if (begin_drag) begin
               n_push = 2'd2;
            end else if (drag_active_ff) begin
               res0   = res1;
               n_push = 2'd1;
            end else if (s1_vis_ff) begin
               res0            = res1;
               res0.event_code = pcdc_pkg::EVT_HOVER;
               n_push          = 2'd1;
            end
         end
         pcdc_pkg::REQ_DOWN: begin
            // ignore a second button and buttons beyond the configured count
            if (!held_valid_ff && ({1'b0, s1_btn_ff} < 3'(NUM_BUTTONS))) begin
               held_valid_in    = 1'b1;
               held_button_in   = s1_btn_ff;
               click_pending_in = 1'b1;
               press_x_in       = s1_x_ff;
               press_y_in       = s1_y_ff;
            end
         end
         pcdc_pkg::REQ_UP: begin
            res0 = '{event_code: pcdc_pkg::EVT_DRAG_END, event_button: s1_btn_ff,
                     out_x: cx, out_y: cy, hide_cursor: 1'b0,
                     show_cursor: (held_mode == pcdc_pkg::MODE_HIDE), last: 1'b1};
            if (held_valid_ff && (s1_btn_ff == held_button_ff)) begin
               if (drag_active_ff) begin
                  drag_active_in = 1'b0;
                  n_push         = 2'd1;
               end else if (click_pending_ff) begin
                  click_pending_in = 1'b0;
                  res0.event_code  = pcdc_pkg::EVT_CLICK;
                  res0.show_cursor = 1'b0;
                  n_push           = 2'd1;
               end
               held_valid_in  = 1'b0;
               held_button_in = '0;
            end
         end
         default: begin
            // abort: keep the held button and the click, end the drag only
            drag_active_in = 1'b0;
            res0 = '{event_code: pcdc_pkg::EVT_DRAG_ABORT,
                     event_button: held_valid_ff ? held_button_ff : 2'd0,
                     out_x: '0, out_y: '0, hide_cursor: 1'b0, show_cursor: 1'b0,
                     last: 1'b1};
            n_push = 2'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff    <= 1'b0;
         held_button_ff   <= '0;
         drag_active_ff   <= 1'b0;
         click_pending_ff <= 1'b0;
         press_x_ff       <= '0;
         press_y_ff       <= '0;
      end else if (s1_go) begin
         held_valid_ff    <= held_valid_in;
         held_button_ff   <= held_button_in;
         drag_active_ff   <= drag_active_in;
         click_pending_ff <= click_pending_in;
         press_x_ff       <= press_x_in;
         press_y_ff       <= press_y_in;
      end
   end

   // ---------------- result queue ----------------
   result_type      queue_ff [QDEPTH];
   logic [QPTR-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR:0]   push_cnt;
   logic            pop;
   result_type      head;

   assign push_cnt = s1_go ? (QPTR+1)'(n_push) : '0;
   assign pop      = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPTR'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + QPTR'(pop);
         count_ff  <= count_ff + push_cnt - (QPTR+1)'(pop);
      end
      if (push_cnt != '0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == (QPTR+1)'(2)) begin
         queue_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assign head                = queue_ff[rd_ptr_ff];
   assign rsp_ch.valid        = (count_ff != '0);
   assign rsp_ch.event_code   = head.event_code;
   assign rsp_ch.event_button = head.event_button;
   assign rsp_ch.out_x        = head.out_x;
   assign rsp_ch.out_y        = head.out_y;
   assign rsp_ch.hide_cursor  = head.hide_cursor;
   assign rsp_ch.show_cursor  = head.show_cursor;
   assign rsp_ch.last         = head.last;

   // ---------------- assertions ----------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR+1)'(QDEPTH))
      else $error("result queue overflow");

   a_drag_needs_button: assert property (@(posedge clock) disable iff (reset)
      drag_active_ff |-> held_valid_ff)
      else $error("drag active with no button held");

   a_click_or_drag: assert property (@(posedge clock) disable iff (reset)
      !(drag_active_ff && click_pending_ff))
      else $error("click still armed during a drag");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("input register changed while blocked");

endmodule
